// ===== sv/tgs_pkg.sv =====
// Shared constants, codes and types of the timestamp gap segmenter.
package tgs_pkg;

    localparam int TIME_W          = 40;
    localparam int GAP_W           = 17;
    localparam int STATUS_W        = 4;
    localparam int SEG_IDX_W       = 6;
    localparam int OP_W            = 3;
    localparam int CFG_IDX_W       = 1;
    localparam int TABLE_DEPTH_DEF = 64;

    localparam logic [GAP_W-1:0]  GAP_LIMIT_RST = 17'd7200;
    localparam logic [TIME_W-1:0] MIDNIGHT_LAST = 40'd86399;

    localparam logic [OP_W-1:0] OP_LOAD  = 3'd0;
    localparam logic [OP_W-1:0] OP_NEXT  = 3'd1;
    localparam logic [OP_W-1:0] OP_CHECK = 3'd2;
    localparam logic [OP_W-1:0] OP_RESET = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK         = 4'd0;
    localparam logic [STATUS_W-1:0] ST_FILLED     = 4'd1;
    localparam logic [STATUS_W-1:0] ST_SKIPPED    = 4'd2;
    localparam logic [STATUS_W-1:0] ST_RESTART    = 4'd3;
    localparam logic [STATUS_W-1:0] ST_SPLIT      = 4'd4;
    localparam logic [STATUS_W-1:0] ST_NO_SEGMENT = 4'd5;
    localparam logic [STATUS_W-1:0] ST_UNEXPECTED = 4'd6;
    localparam logic [STATUS_W-1:0] ST_NO_MORE    = 4'd7;
    localparam logic [STATUS_W-1:0] ST_FULL       = 4'd8;

    localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MIDNIGHT_WRAP = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] beg_sec;
        logic [TIME_W-1:0] end_sec;
        logic              is_open;
    } entry_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TIME_W-1:0] time_sec;
        logic [TIME_W-1:0] end_sec;
        logic              open_end;
        logic              init_mode;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [GAP_W-1:0]     fill_count;
        logic [TIME_W-1:0]    fill_from;
        logic [TIME_W-1:0]    seg_begin;
        logic [TIME_W-1:0]    seg_end;
        logic                 seg_open;
        logic [SEG_IDX_W-1:0] seg_index;
    } result_t;

    typedef enum logic [2:0] {
        CHK_SEQ,
        CHK_RESTART,
        CHK_SKIP,
        CHK_FILL,
        CHK_BREAK
    } chk_class_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LATCH,
        ACT_LOAD,
        ACT_ENSURE,
        ACT_NEXT_SEL,
        ACT_NEXT_OUT,
        ACT_CHECK,
        ACT_RESET_TRK,
        ACT_CLEAR,
        ACT_SRCH_RD,
        ACT_SRCH_CK,
        ACT_SH_RD,
        ACT_SH_WR,
        ACT_WR_HI,
        ACT_WR_LO,
        ACT_EMIT
    } act_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_NEXT_SEL,
        S_NEXT_OUT,
        S_SRCH_RD,
        S_SRCH_CK,
        S_SH_RD,
        S_SH_WR,
        S_WR_HI,
        S_WR_LO,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        chk_class_t      cls;
        logic            tbl_full;
        logic            next_past;
        logic            hit;
        logic            split_ok;
        logic            srch_last;
        logic            sh_more;
        logic            out_free;
    } ctl_stat_t;

endpackage

// ===== sv/tgs_if.sv =====
// Handshake channels for input items and result items.
interface tgs_item_if import tgs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] time_sec;
    logic [TIME_W-1:0] end_sec;
    logic              open_end;
    logic              init_mode;

    modport source (output valid, op, time_sec, end_sec, open_end, init_mode, input ready);
    modport sink (input valid, op, time_sec, end_sec, open_end, init_mode, output ready);
endinterface

interface tgs_result_if import tgs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [GAP_W-1:0]     fill_count;
    logic [TIME_W-1:0]    fill_from;
    logic [TIME_W-1:0]    seg_begin;
    logic [TIME_W-1:0]    seg_end;
    logic                 seg_open;
    logic [SEG_IDX_W-1:0] seg_index;

    modport source (output valid, status, fill_count, fill_from, seg_begin, seg_end, seg_open,
                    seg_index, input ready);
    modport sink (input valid, status, fill_count, fill_from, seg_begin, seg_end, seg_open,
                  seg_index, output ready);
endinterface

// ===== sv/tgs_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
module tgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/tgs_ctrl.sv =====
// Sequencer: walks each transaction through decode, table search, shift and result hand-off.
module tgs_ctrl import tgs_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ctl_stat_t stat,
    output act_t      act
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        act        = ACT_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    act        = ACT_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_EMIT;
                case (stat.op)
                    OP_LOAD:  act = ACT_LOAD;
                    OP_NEXT:
                    begin
                        act        = ACT_ENSURE;
                        state_next = S_NEXT_SEL;
                    end
                    OP_CHECK:
                    begin
                        act = ACT_CHECK;
                        if (stat.cls == CHK_BREAK)
                        begin
                            state_next = S_SRCH_RD;
                        end
                    end
                    OP_RESET: act = ACT_RESET_TRK;
                    OP_CLEAR: act = ACT_CLEAR;
                    default:  act = ACT_NONE;
                endcase
            end
            S_NEXT_SEL:
            begin
                act        = ACT_NEXT_SEL;
                state_next = stat.next_past ? S_EMIT : S_NEXT_OUT;
            end
            S_NEXT_OUT:
            begin
                act        = ACT_NEXT_OUT;
                state_next = S_EMIT;
            end
            S_SRCH_RD:
            begin
                act        = ACT_SRCH_RD;
                state_next = S_SRCH_CK;
            end
            S_SRCH_CK:
            begin
                act = ACT_SRCH_CK;
                if (stat.hit)
                begin
                    state_next = (stat.split_ok && !stat.tbl_full) ? S_SH_RD : S_EMIT;
                end
                else
                begin
                    state_next = stat.srch_last ? S_EMIT : S_SRCH_RD;
                end
            end
            S_SH_RD:
            begin
                act        = ACT_SH_RD;
                state_next = stat.sh_more ? S_SH_WR : S_WR_HI;
            end
            S_SH_WR:
            begin
                act        = ACT_SH_WR;
                state_next = S_SH_RD;
            end
            S_WR_HI:
            begin
                act        = ACT_WR_HI;
                state_next = S_WR_LO;
            end
            S_WR_LO:
            begin
                act        = ACT_WR_LO;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    act        = ACT_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/tgs_dp.sv =====
// Datapath: tracker and table registers, interval RAM, stamp classification, result registers.
module tgs_dp import tgs_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [GAP_W-1:0]     cfg_data,
    input  item_t                item,
    input  act_t                 act,
    output ctl_stat_t            stat,
    output result_t              out_data,
    output logic                 out_valid,
    input  logic                 out_ready
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // configuration and tracker
    logic [GAP_W-1:0]  gap_limit_reg;
    logic              wrap_reg;
    logic [TIME_W-1:0] prev_stamp_reg;
    logic              prev_valid_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  cur_reg;
    logic              cur_none_reg;
    logic              out_valid_reg;

    // per-transaction working registers
    item_t             item_reg;
    result_t           res_reg;
    result_t           out_reg;
    entry_t            entry_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  k_reg;
    logic [CNT_W-1:0]  j_reg;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_wr_addr;
    entry_t            ram_wr_data;
    logic [IDX_W-1:0]  ram_rd_addr;
    logic [$bits(entry_t)-1:0] ram_rd_data;
    entry_t            rd_entry;

    logic [TIME_W-1:0] t;
    logic [TIME_W:0]   prev_p1;
    logic [TIME_W-1:0] gap;
    logic [TIME_W-1:0] gap_m1;
    logic              in_seq;
    chk_class_t        cls;
    logic              cnt_zero;
    logic              tbl_full;
    logic [CNT_W:0]    nx;
    logic              next_past;
    logic              hit;
    logic              split_ok;
    logic              srch_last;
    logic              sh_more;
    logic [CNT_W-1:0]  jm1;
    logic [IDX_W-1:0]  idx_p1;
    logic [CNT_W+SEG_IDX_W-1:0] cnt_ext;
    logic [CNT_W+SEG_IDX_W-1:0] cur_ext;
    logic [IDX_W+SEG_IDX_W-1:0] idx_ext;
    entry_t            default_entry;

    assign t        = item_reg.time_sec;
    assign prev_p1  = {1'b0, prev_stamp_reg} + {{TIME_W{1'b0}}, 1'b1};
    assign gap      = t - prev_stamp_reg;
    assign gap_m1   = t + ~prev_stamp_reg;
    assign in_seq   = !prev_valid_reg || ({1'b0, t} == prev_p1)
                   || (wrap_reg && (t == '0) && (prev_stamp_reg == MIDNIGHT_LAST));

    always_comb
    begin
        if (in_seq)
        begin
            cls = CHK_SEQ;
        end
        else if (item_reg.init_mode)
        begin
            cls = CHK_RESTART;
        end
        else if (prev_stamp_reg >= t)
        begin
            cls = CHK_SKIP;
        end
        else if (gap < {{(TIME_W-GAP_W){1'b0}}, gap_limit_reg})
        begin
            cls = CHK_FILL;
        end
        else
        begin
            cls = CHK_BREAK;
        end
    end

    assign cnt_zero  = (count_reg == '0);
    assign tbl_full  = (count_reg >= CNT_W'(TABLE_DEPTH));
    assign nx        = cur_none_reg ? '0 : ({1'b0, cur_reg} + {{CNT_W{1'b0}}, 1'b1});
    assign next_past = (nx >= {1'b0, count_reg});

    assign rd_entry  = entry_t'(ram_rd_data);
    assign hit       = ((prev_stamp_reg > rd_entry.beg_sec) && (prev_stamp_reg <= rd_entry.end_sec))
                    || rd_entry.is_open;
    assign split_ok  = (t <= rd_entry.end_sec) || rd_entry.is_open;
    assign srch_last = ((k_reg + CNT_W'(1)) >= count_reg);
    assign sh_more   = (j_reg > (CNT_W'(idx_reg) + CNT_W'(1)));
    assign jm1       = j_reg - CNT_W'(1);
    assign idx_p1    = idx_reg + IDX_W'(1);

    assign cnt_ext   = {{SEG_IDX_W{1'b0}}, count_reg};
    assign cur_ext   = {{SEG_IDX_W{1'b0}}, cur_reg};
    assign idx_ext   = {{SEG_IDX_W{1'b0}}, idx_reg};

    // empty table behaves as one open interval from zero
    assign default_entry = '{beg_sec: '0, end_sec: '0, is_open: 1'b1};

    always_comb
    begin
        stat.op        = item_reg.op;
        stat.cls       = cls;
        stat.tbl_full  = tbl_full;
        stat.next_past = next_past;
        stat.hit       = hit;
        stat.split_ok  = split_ok;
        stat.srch_last = srch_last;
        stat.sh_more   = sh_more;
        stat.out_free  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        ram_we      = 1'b0;
        ram_wr_addr = '0;
        ram_wr_data = default_entry;
        ram_rd_addr = '0;
        case (act)
            ACT_LOAD:
            begin
                ram_we      = !tbl_full;
                ram_wr_addr = count_reg[IDX_W-1:0];
                ram_wr_data = '{beg_sec: t, end_sec: item_reg.end_sec,
                                is_open: item_reg.open_end};
            end
            ACT_ENSURE:
            begin
                ram_we = cnt_zero;
            end
            ACT_CHECK:
            begin
                ram_we = cnt_zero && (cls == CHK_BREAK);
            end
            ACT_NEXT_SEL:
            begin
                ram_rd_addr = nx[IDX_W-1:0];
            end
            ACT_SRCH_RD:
            begin
                ram_rd_addr = k_reg[IDX_W-1:0];
            end
            ACT_SH_RD:
            begin
                ram_rd_addr = jm1[IDX_W-1:0];
            end
            ACT_SH_WR:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = j_reg[IDX_W-1:0];
                ram_wr_data = rd_entry;
            end
            ACT_WR_HI:
            begin
                // upper half keeps the old end and open flag, begins at the new stamp
                ram_we      = 1'b1;
                ram_wr_addr = idx_p1;
                ram_wr_data = '{beg_sec: t, end_sec: entry_reg.end_sec,
                                is_open: entry_reg.is_open};
            end
            ACT_WR_LO:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = idx_reg;
                ram_wr_data = '{beg_sec: entry_reg.beg_sec, end_sec: prev_stamp_reg,
                                is_open: 1'b0};
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    tgs_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_limit_reg  <= GAP_LIMIT_RST;
            wrap_reg       <= 1'b0;
            prev_stamp_reg <= '0;
            prev_valid_reg <= 1'b0;
            count_reg      <= '0;
            cur_reg        <= '0;
            cur_none_reg   <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GAP_LIMIT:     gap_limit_reg <= cfg_data;
                    REG_MIDNIGHT_WRAP: wrap_reg      <= cfg_data[0];
                    default:           ;
                endcase
            end
            case (act)
                ACT_LOAD:
                begin
                    if (!tbl_full)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                end
                ACT_ENSURE:
                begin
                    if (cnt_zero)
                    begin
                        count_reg <= CNT_W'(1);
                    end
                end
                ACT_NEXT_SEL:
                begin
                    cur_none_reg <= 1'b0;
                    if (next_past)
                    begin
                        cur_reg <= count_reg;
                    end
                    else
                    begin
                        cur_reg        <= nx[CNT_W-1:0];
                        prev_valid_reg <= 1'b0;
                    end
                end
                ACT_CHECK:
                begin
                    case (cls)
                        CHK_SEQ:
                        begin
                            prev_stamp_reg <= t;
                            prev_valid_reg <= 1'b1;
                        end
                        CHK_RESTART: prev_valid_reg <= 1'b0;
                        CHK_FILL:    prev_stamp_reg <= t;
                        CHK_BREAK:
                        begin
                            if (cnt_zero)
                            begin
                                count_reg <= CNT_W'(1);
                            end
                        end
                        default: ;
                    endcase
                end
                ACT_RESET_TRK:
                begin
                    prev_valid_reg <= 1'b0;
                end
                ACT_CLEAR:
                begin
                    count_reg    <= '0;
                    cur_none_reg <= 1'b1;
                end
                ACT_SRCH_CK:
                begin
                    // found an interval but the new stamp lies beyond it
                    if (hit && !split_ok)
                    begin
                        prev_stamp_reg <= t;
                    end
                end
                ACT_WR_LO:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                default: ;
            endcase
            if (act == ACT_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (act)
            ACT_LATCH:
            begin
                item_reg <= item;
                res_reg  <= '0;
            end
            ACT_LOAD:
            begin
                if (tbl_full)
                begin
                    res_reg.status <= ST_FULL;
                end
                else
                begin
                    res_reg.seg_index <= cnt_ext[SEG_IDX_W-1:0];
                end
            end
            ACT_NEXT_SEL:
            begin
                if (next_past)
                begin
                    res_reg.status <= ST_NO_MORE;
                end
            end
            ACT_NEXT_OUT:
            begin
                res_reg.seg_begin <= rd_entry.beg_sec;
                res_reg.seg_end   <= rd_entry.end_sec;
                res_reg.seg_open  <= rd_entry.is_open;
                res_reg.seg_index <= cur_ext[SEG_IDX_W-1:0];
            end
            ACT_CHECK:
            begin
                case (cls)
                    CHK_RESTART: res_reg.status <= ST_RESTART;
                    CHK_SKIP:    res_reg.status <= ST_SKIPPED;
                    CHK_FILL:
                    begin
                        res_reg.status     <= ST_FILLED;
                        res_reg.fill_count <= gap_m1[GAP_W-1:0];
                        res_reg.fill_from  <= prev_stamp_reg;
                    end
                    CHK_BREAK:   k_reg <= '0;
                    default:     ;
                endcase
            end
            ACT_SRCH_CK:
            begin
                if (hit)
                begin
                    entry_reg <= rd_entry;
                    idx_reg   <= k_reg[IDX_W-1:0];
                    j_reg     <= count_reg;
                    if (!split_ok)
                    begin
                        res_reg.status <= ST_UNEXPECTED;
                    end
                    else if (tbl_full)
                    begin
                        res_reg.status <= ST_FULL;
                    end
                end
                else
                begin
                    k_reg <= k_reg + CNT_W'(1);
                    if (srch_last)
                    begin
                        res_reg.status <= ST_NO_SEGMENT;
                    end
                end
            end
            ACT_SH_WR:
            begin
                j_reg <= jm1;
            end
            ACT_WR_LO:
            begin
                res_reg.status    <= ST_SPLIT;
                res_reg.seg_index <= idx_ext[SEG_IDX_W-1:0];
            end
            ACT_EMIT:
            begin
                out_reg <= res_reg;
            end
            default: ;
        endcase
    end

    assign out_data  = out_reg;
    assign out_valid = out_valid_reg;

endmodule

// ===== sv/timestamp_gap_segmenter_unit.sv =====
// Top level of the timestamp gap segmenter: channels, configuration port and checks.
// One transaction is worked on at a time; a new one is taken while the previous result still
// waits in the output register. Load, reset, clear, an unused op code and a stamp check that is
// in sequence, skipped, restarted or filled pass from acceptance through decode to the emit
// state; next-interval adds a select state, and an output state when it starts an interval.
// A long gap searches the interval table and then shifts it open, both through the one
// read and one write port of the interval RAM: a read and a check for each entry searched, a
// read and a write for each entry moved up, then writes of the upper and lower halves. Search
// and shift together cover the table at most once. A result register that is still full holds
// the transaction in its emit state until it drains.
// The table needs no clearing after reset; its entries are only read below the interval count.
module timestamp_gap_segmenter_unit import tgs_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [GAP_W-1:0]     cfg_data,
    tgs_item_if.sink             item,
    tgs_result_if.source         result
);

    item_t     item_data;
    result_t   res_data;
    ctl_stat_t stat;
    act_t      act;
    logic      in_ready;
    logic      out_valid;

    assign item_data = '{op: item.op, time_sec: item.time_sec, end_sec: item.end_sec,
                         open_end: item.open_end, init_mode: item.init_mode};
    assign item.ready = in_ready;

    tgs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .act      (act)
    );

    tgs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_data),
        .act       (act),
        .stat      (stat),
        .out_data  (res_data),
        .out_valid (out_valid),
        .out_ready (result.ready)
    );

    assign result.valid      = out_valid;
    assign result.status     = res_data.status;
    assign result.fill_count = res_data.fill_count;
    assign result.fill_from  = res_data.fill_from;
    assign result.seg_begin  = res_data.seg_begin;
    assign result.seg_end    = res_data.seg_end;
    assign result.seg_open   = res_data.seg_open;
    assign result.seg_index  = res_data.seg_index;

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready)
        else $error("input taken again straight after a transaction");

    a_split_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (act == ACT_WR_LO) |-> !stat.tbl_full)
        else $error("interval split completing into a full table");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(act == ACT_EMIT))
        else $error("result shown without a finished transaction");
`endif

endmodule

// ===== tb/tgs_checker.sv =====
// Checker for the timestamp gap segmenter: predicts each result and compares it with the block.
module tgs_checker import tgs_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [GAP_W-1:0]     cfg_data,
    tgs_item_if                  item,
    tgs_result_if                result,
    output int                   failures,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEG_DEPTH   = TABLE_DEPTH_DEF;
    localparam int MAX_PRINTED = 40;

    // Register copies
    logic [GAP_W-1:0] gap_limit;
    logic             wrap_en;

    // Tracker and interval table
    logic [TIME_W-1:0] last_stamp;
    logic              have_prev;
    logic [TIME_W-1:0] seg_beg [SEG_DEPTH];
    logic [TIME_W-1:0] seg_end [SEG_DEPTH];
    logic              seg_open [SEG_DEPTH];
    int                seg_count;
    int                cur_seg;     // -1 while no interval has been started

    result_t expected_results[$];
    int      results_seen;

    task automatic report(string what);
        failures++;
        if (failures <= MAX_PRINTED)
            $display("[%0t] result %0d: %s", $time, results_seen, what);
    endtask

    task automatic match_field(string name, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
        if (got !== want)
            report($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // An empty table behaves as one open interval from 0
    function automatic void place_default();
        if (seg_count == 0)
        begin
            seg_beg[0]  = '0;
            seg_end[0]  = '0;
            seg_open[0] = 1'b1;
            seg_count   = 1;
        end
    endfunction

    function automatic result_t segment_step(item_t it);
        result_t           r;
        logic [TIME_W-1:0] gap;
        int                nx;
        int                i;
        bit                hit;

        r = '0;
        r.status = ST_OK;
        case (it.op)
            OP_LOAD:
            begin
                if (seg_count >= SEG_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    seg_beg[seg_count]  = it.time_sec;
                    seg_end[seg_count]  = it.end_sec;
                    seg_open[seg_count] = it.open_end;
                    r.seg_index         = SEG_IDX_W'(seg_count);
                    seg_count++;
                end
            end
            OP_NEXT:
            begin
                place_default();
                nx = (cur_seg < 0) ? 0 : cur_seg + 1;
                if (nx >= seg_count)
                begin
                    cur_seg  = seg_count;
                    r.status = ST_NO_MORE;
                end
                else
                begin
                    cur_seg     = nx;
                    have_prev   = 1'b0;
                    r.seg_begin = seg_beg[nx];
                    r.seg_end   = seg_end[nx];
                    r.seg_open  = seg_open[nx];
                    r.seg_index = SEG_IDX_W'(nx);
                end
            end
            OP_CHECK:
            begin
                if (!have_prev || {1'b0, it.time_sec} == {1'b0, last_stamp} + 41'd1 ||
                    (wrap_en && it.time_sec == '0 && last_stamp == MIDNIGHT_LAST))
                begin
                    last_stamp = it.time_sec;
                    have_prev  = 1'b1;
                end
                else if (it.init_mode)
                begin
                    have_prev = 1'b0;
                    r.status  = ST_RESTART;
                end
                else if (last_stamp >= it.time_sec)
                    r.status = ST_SKIPPED;
                else
                begin
                    gap = it.time_sec - last_stamp;
                    if (gap < TIME_W'(gap_limit))
                    begin
                        r.status     = ST_FILLED;
                        r.fill_count = GAP_W'(gap - 1);
                        r.fill_from  = last_stamp;
                        last_stamp   = it.time_sec;
                    end
                    else
                    begin
                        // long gap: find the interval holding the previous stamp
                        place_default();
                        hit = 1'b0;
                        i   = 0;
                        while (!hit && i < seg_count)
                        begin
                            if ((last_stamp > seg_beg[i] && last_stamp <= seg_end[i]) || seg_open[i])
                                hit = 1'b1;
                            else
                                i++;
                        end
                        if (!hit)
                            r.status = ST_NO_SEGMENT;
                        else if (it.time_sec <= seg_end[i] || seg_open[i])
                        begin
                            if (seg_count >= SEG_DEPTH)
                                r.status = ST_FULL;
                            else
                            begin
                                for (int j = seg_count; j > i; j--)
                                begin
                                    seg_beg[j]  = seg_beg[j-1];
                                    seg_end[j]  = seg_end[j-1];
                                    seg_open[j] = seg_open[j-1];
                                end
                                seg_end[i]   = last_stamp;
                                seg_open[i]  = 1'b0;
                                seg_beg[i+1] = it.time_sec;
                                seg_count++;
                                r.status    = ST_SPLIT;
                                r.seg_index = SEG_IDX_W'(i);
                            end
                        end
                        else
                        begin
                            last_stamp = it.time_sec;
                            r.status   = ST_UNEXPECTED;
                        end
                    end
                end
            end
            OP_RESET:
                have_prev = 1'b0;
            OP_CLEAR:
            begin
                seg_count = 0;
                cur_seg   = -1;
            end
            default:
                ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t got;
        result_t want;
        item_t   it;

        if (!rst_n)
        begin
            gap_limit  = GAP_LIMIT_RST;
            wrap_en    = 1'b0;
            last_stamp = '0;
            have_prev  = 1'b0;
            seg_count  = 0;
            cur_seg    = -1;
            expected_results.delete();
            results_seen = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_GAP_LIMIT)
                    gap_limit = cfg_data;
                else if (cfg_index == REG_MIDNIGHT_WRAP)
                    wrap_en = cfg_data[0];
            end
            // results first: a transaction taken at this edge cannot already have its result
            if (result.valid && result.ready)
            begin
                got = '{status: result.status, fill_count: result.fill_count,
                        fill_from: result.fill_from, seg_begin: result.seg_begin,
                        seg_end: result.seg_end, seg_open: result.seg_open,
                        seg_index: result.seg_index};
                if (expected_results.size() == 0)
                    report("result arrived with no transaction waiting for it");
                else
                begin
                    want = expected_results.pop_front();
                    match_field("status", got.status, want.status);
                    match_field("fill_count", got.fill_count, want.fill_count);
                    match_field("fill_from", got.fill_from, want.fill_from);
                    match_field("seg_begin", got.seg_begin, want.seg_begin);
                    match_field("seg_end", got.seg_end, want.seg_end);
                    match_field("seg_open", got.seg_open, want.seg_open);
                    match_field("seg_index", got.seg_index, want.seg_index);
                end
                results_seen++;
            end
            if (item.valid && item.ready)
            begin
                it = '{op: item.op, time_sec: item.time_sec, end_sec: item.end_sec,
                       open_end: item.open_end, init_mode: item.init_mode};
                expected_results.push_back(segment_step(it));
            end
        end
        pending = expected_results.size();
    end

endmodule

// ===== tb/timestamp_gap_segmenter_unit_test.sv =====
// Testbench top of the timestamp gap segmenter: clock, reset, stimulus, flow control and verdict.
module timestamp_gap_segmenter_unit_test;
    import tgs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                CLK_HALF      = 5;
    localparam int                DRAIN_CYCLES  = 4 * TABLE_DEPTH_DEF + 16;
    localparam int                LONG_HOLD     = 400;
    localparam int                PHASE_ITEMS   = 200;
    localparam logic [OP_W-1:0]   OP_SPARE_FIRST = OP_CLEAR + 3'd1;
    localparam logic [TIME_W-1:0] STAMP_MAX     = {TIME_W{1'b1}};

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [GAP_W-1:0]     cfg_data;
    int                   failures;
    int                   pending;

    tgs_item_if   item_ch ();
    tgs_result_if result_ch ();

    timestamp_gap_segmenter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    tgs_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch),
        .failures  (failures),
        .pending   (pending)
    );

    always #(CLK_HALF) clk = ~clk;

    item_t             stamp_items[$];
    logic [GAP_W-1:0]  cur_gap;
    logic              cur_wrap;
    logic [TIME_W-1:0] t_cur;
    bit                hold_req;

    function automatic logic [TIME_W-1:0] random_stamp();
        return {8'($urandom), 32'($urandom)};
    endfunction

    function automatic void add_item(logic [OP_W-1:0] op, logic [TIME_W-1:0] t,
                                     logic [TIME_W-1:0] e, logic oe, logic init);
        stamp_items.push_back('{op: op, time_sec: t, end_sec: e, open_end: oe, init_mode: init});
    endfunction

    // One session: optional clear, interval loads, steps into the table, optional reset, a stamp run
    function automatic void add_session();
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] b;
        logic [TIME_W-1:0] e;
        logic [TIME_W-1:0] t;
        int                n_loads;
        int                pick;
        int                hi;

        case ($urandom_range(0, 19))
            0, 1, 2: base = MIDNIGHT_LAST - TIME_W'($urandom_range(0, 40));
            3, 4, 5: base = random_stamp();
            6, 7:    base = STAMP_MAX - TIME_W'($urandom_range(0, 40));
            default: base = TIME_W'($urandom_range(0, 500000));
        endcase
        if ($urandom_range(0, 3) == 0)
            add_item(OP_CLEAR, random_stamp(), random_stamp(), 1'($urandom), 1'($urandom));
        n_loads = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 4);
        b = base;
        for (int k = 0; k < n_loads; k++)
        begin
            e = b + TIME_W'($urandom_range(10, 30000));
            add_item(OP_LOAD, b, e, ($urandom_range(0, 3) == 0), 1'($urandom));
            b = e + TIME_W'($urandom_range(1, 5000));
        end
        repeat ($urandom_range(1, 2))
            add_item(OP_NEXT, random_stamp(), random_stamp(), 1'($urandom), 1'($urandom));
        if ($urandom_range(0, 1) == 0)
            add_item(OP_RESET, random_stamp(), random_stamp(), 1'($urandom), 1'($urandom));
        // now and then start past every loaded interval
        t_cur = ($urandom_range(0, 7) == 0) ? b + 40000 : base;

        repeat ($urandom_range(8, 60))
        begin
            pick = $urandom_range(0, 99);
            if (pick < 68)
            begin
                t_cur = t_cur + 1;
                add_item(OP_CHECK, t_cur, random_stamp(), 1'($urandom),
                         ($urandom_range(0, 15) == 0));
            end
            else if (pick < 76)
            begin
                hi = int'(cur_gap) - 1;
                if (hi > 60 && $urandom_range(0, 3) != 0)
                    hi = 60;
                t_cur = (hi >= 2) ? t_cur + TIME_W'($urandom_range(2, hi)) : t_cur + 1;
                add_item(OP_CHECK, t_cur, random_stamp(), 1'($urandom), 1'b0);
            end
            else if (pick < 82)
            begin
                t_cur = t_cur + TIME_W'(cur_gap) + TIME_W'(($urandom_range(0, 3) == 0) ?
                        $urandom_range(0, 200000) : $urandom_range(0, 50));
                add_item(OP_CHECK, t_cur, random_stamp(), 1'($urandom), 1'b0);
                if ($urandom_range(0, 4) < 3)
                    add_item(OP_RESET, random_stamp(), random_stamp(), 1'($urandom), 1'($urandom));
            end
            else if (pick < 88)
            begin
                t = t_cur - TIME_W'($urandom_range(0, 4));
                add_item(OP_CHECK, t, random_stamp(), 1'($urandom), 1'b0);
            end
            else if (pick < 91)
            begin
                t_cur = t_cur + TIME_W'($urandom_range(2, 100));
                add_item(OP_CHECK, t_cur, random_stamp(), 1'($urandom), 1'b1);
            end
            else if (pick < 94)
            begin
                add_item(OP_RESET, random_stamp(), random_stamp(), 1'($urandom), 1'($urandom));
                add_item(OP_CHECK, MIDNIGHT_LAST, random_stamp(), 1'($urandom), 1'b0);
                add_item(OP_CHECK, '0, random_stamp(), 1'($urandom), 1'b0);
                t_cur = cur_wrap ? '0 : MIDNIGHT_LAST;
            end
            else if (pick < 97)
                add_item(OP_NEXT, random_stamp(), random_stamp(), 1'($urandom), 1'($urandom));
            else
                add_item(OP_W'($urandom_range(0, (1 << OP_W) - 1)), random_stamp(),
                         random_stamp(), 1'($urandom), 1'($urandom));
        end
    endfunction

    task automatic put_item(item_t it);
        item_ch.valid     <= 1'b1;
        item_ch.op        <= it.op;
        item_ch.time_sec  <= it.time_sec;
        item_ch.end_sec   <= it.end_sec;
        item_ch.open_end  <= it.open_end;
        item_ch.init_mode <= it.init_mode;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    // Sends the queued items in bursts; asks for a long receiver hold after hold_at items
    task automatic drive_items(int hold_at);
        int burst;
        int gap;
        int sent;

        sent = 0;
        while (stamp_items.size() != 0)
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && stamp_items.size() != 0)
            begin
                if (sent == hold_at)
                    hold_req = 1'b1;
                put_item(stamp_items.pop_front());
                sent++;
                burst--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        item_ch.valid <= 1'b0;
    endtask

    task automatic settle(int cycles);
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (cycles) @(posedge clk);
    endtask

    task automatic set_config(logic [GAP_W-1:0] gap, logic wrap);
        cfg_we    <= 1'b1;
        cfg_index <= REG_GAP_LIMIT;
        cfg_data  <= gap;
        @(posedge clk);
        cfg_index <= REG_MIDNIGHT_WRAP;
        cfg_data  <= GAP_W'(wrap);
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_gap  = gap;
        cur_wrap = wrap;
    endtask

    task automatic run_phase(bit with_hold);
        while (stamp_items.size() < PHASE_ITEMS)
            add_session();
        drive_items(with_hold ? $urandom_range(20, PHASE_ITEMS / 2) : -1);
        settle(DRAIN_CYCLES);
    endtask

    // Receiver: changes its stall pattern every so often, and holds off on request
    initial
    begin : result_drain
        int run_left;
        int mode;
        int hold_left;

        run_left = 0;
        mode = 0;
        hold_left = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    mode     = $urandom_range(0, 3);
                    run_left = $urandom_range(10, 150);
                end
                run_left--;
                case (mode)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
                    2:       result_ch.ready <= ($urandom_range(0, 1) != 0);
                    default: result_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        #40_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_GAP_LIMIT;
        cfg_data           = '0;
        item_ch.valid      = 1'b0;
        item_ch.op         = OP_LOAD;
        item_ch.time_sec   = '0;
        item_ch.end_sec    = '0;
        item_ch.open_end   = 1'b0;
        item_ch.init_mode  = 1'b0;
        cur_gap            = GAP_LIMIT_RST;
        cur_wrap           = 1'b0;
        t_cur              = '0;
        hold_req           = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed run on the reset register values
        add_item(OP_CHECK, 40'd5, '0, 1'b0, 1'b0);          // first stamp
        add_item(OP_CHECK, 40'd6, STAMP_MAX, 1'b1, 1'b0);   // in sequence
        add_item(OP_CHECK, 40'd6, '0, 1'b0, 1'b0);          // equal: skipped
        add_item(OP_CHECK, 40'd3, '0, 1'b0, 1'b0);          // older: skipped
        add_item(OP_CHECK, 40'd10, '0, 1'b0, 1'b0);         // short gap filled
        add_item(OP_CHECK, 40'd7210, '0, 1'b0, 1'b0);       // long gap splits the empty table
        add_item(OP_CHECK, 40'd11, '0, 1'b0, 1'b1);
        add_item(OP_CHECK, 40'd20, '0, 1'b0, 1'b1);         // out of sequence in init mode: restart
        add_item(OP_CHECK, 40'd20, '0, 1'b0, 1'b0);
        repeat (4) add_item(OP_NEXT, '0, '0, 1'b0, 1'b0);   // last two run past the table
        add_item(OP_LOAD, STAMP_MAX, '0, 1'b1, 1'b0);
        add_item(OP_LOAD, '0, STAMP_MAX, 1'b0, 1'b1);
        add_item(OP_RESET, '0, '0, 1'b0, 1'b0);
        add_item(OP_CHECK, STAMP_MAX, '0, 1'b0, 1'b0);
        add_item(OP_CHECK, '0, '0, 1'b0, 1'b0);
        add_item(OP_CLEAR, '0, '0, 1'b0, 1'b0);
        add_item(OP_NEXT, '0, '0, 1'b0, 1'b0);              // default open interval
        for (int s = OP_SPARE_FIRST; s < (1 << OP_W); s++)
            add_item(OP_W'(s), random_stamp(), random_stamp(), 1'b1, 1'b1);
        add_item(OP_RESET, '0, '0, 1'b0, 1'b0);
        add_item(OP_CHECK, MIDNIGHT_LAST, '0, 1'b0, 1'b0);
        add_item(OP_CHECK, '0, '0, 1'b0, 1'b0);             // no wrap: skipped
        add_item(OP_CHECK, 40'd100000, '0, 1'b0, 1'b0);
        drive_items(-1);
        settle(DRAIN_CYCLES);

        set_config(GAP_W'(2), 1'b1);
        run_phase(1'b1);
        set_config(GAP_W'(86400), 1'b0);
        run_phase(1'b0);
        set_config(GAP_LIMIT_RST, 1'b1);
        run_phase(1'b1);
        set_config(GAP_W'($urandom_range(2, 300)), 1'($urandom));
        run_phase(1'b0);
        set_config(GAP_W'($urandom_range(2, 86400)), 1'b1);
        run_phase(1'b0);

        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
